// ===== hw/rtl/mpsa_pkg.sv =====
// Shared types, constants and helper functions for the multi-pool slot allocator.
// Depends on nothing; every other file of the block but mpsa_ram imports it.
`timescale 1ns / 1ps

package mpsa_pkg;

   // pool geometry
   localparam int unsigned NUM_POOLS   = 5;
   localparam int unsigned COUNT_POOL0 = 1024;
   localparam int unsigned COUNT_POOL1 = 1024;
   localparam int unsigned COUNT_POOL2 = 1024;
   localparam int unsigned COUNT_POOL3 = 1024;
   localparam int unsigned COUNT_POOL4 = 32;

   // field widths
   localparam int unsigned ADDR_W    = 48;
   localparam int unsigned ACT_W     = 2;
   localparam int unsigned POOL_W    = 3;
   localparam int unsigned SIDX_W    = 17;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned RIDX_W    = 11;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CNT_W     = 17;

   // slot sizes as shifts; pool 0 is 3 << 3 bytes
   localparam int unsigned SIZE0_SH = 3;
   localparam int unsigned SIZE1_SH = 9;
   localparam int unsigned SIZE2_SH = 4;
   localparam int unsigned SIZE3_SH = 6;
   localparam int unsigned SIZE4_SH = 19;
   localparam int unsigned SIZE0   = 24;
   localparam int unsigned SIZE1   = 512;
   localparam int unsigned SIZE2   = 16;
   localparam int unsigned SIZE3   = 64;
   localparam int unsigned SIZE4   = 512 * 1024;

   // bitmap rows of 32 slots
   localparam int unsigned ROW_BITS = 32;
   localparam int unsigned BIT_W    = 5;

   localparam int unsigned MAX01     = (COUNT_POOL0 > COUNT_POOL1) ? COUNT_POOL0 : COUNT_POOL1;
   localparam int unsigned MAX23     = (COUNT_POOL2 > COUNT_POOL3) ? COUNT_POOL2 : COUNT_POOL3;
   localparam int unsigned MAX03     = (MAX01 > MAX23) ? MAX01 : MAX23;
   localparam int unsigned COUNT_MAX = (MAX03 > COUNT_POOL4) ? MAX03 : COUNT_POOL4;
   localparam int unsigned IDX_W     = ($clog2(COUNT_MAX) > 6) ? $clog2(COUNT_MAX) : 6;
   localparam int unsigned ROW_W     = IDX_W - BIT_W;
   localparam int unsigned ROWS_MAX  = 1 << ROW_W;

   localparam int unsigned ROWS_P0    = (COUNT_POOL0 + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROWS_P1    = (COUNT_POOL1 + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROWS_P2    = (COUNT_POOL2 + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROWS_P3    = (COUNT_POOL3 + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROWS_P4    = (COUNT_POOL4 + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROW_BASE1  = ROWS_P0;
   localparam int unsigned ROW_BASE2  = ROW_BASE1 + ROWS_P1;
   localparam int unsigned ROW_BASE3  = ROW_BASE2 + ROWS_P2;
   localparam int unsigned ROW_BASE4  = ROW_BASE3 + ROWS_P3;
   localparam int unsigned ROWS_TOTAL = ROW_BASE4 + ROWS_P4;
   localparam int unsigned RA_W       = (ROWS_TOTAL > 1) ? $clog2(ROWS_TOTAL) : 1;

   // divide by three through a reciprocal, exact for x below 2**X3_W
   localparam int unsigned X3_W   = IDX_W + 2;
   localparam int unsigned DIV3_K = IDX_W + 3;
   localparam logic [DIV3_K-1:0] DIV3_M = DIV3_K'(((64'd1 << DIV3_K) + 64'd2) / 64'd3);

   localparam int unsigned PROD_W = IDX_W + SIZE4_SH + 1;

   // request queue
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC     = 2'd0,
      ACT_FREE_IDX  = 2'd1,
      ACT_FREE_ADDR = 2'd2,
      ACT_GET       = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_NO_SLOT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_GET    = 2'd2,
      OP_REJECT = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_CHK  = 2'd1,
      BK_MUL  = 2'd2,
      BK_ADD  = 2'd3
   } bk_state_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [POOL_W-1:0] pool;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] base;
   } op_type;

   function automatic logic [CNT_W-1:0] pool_count(input logic [POOL_W-1:0] p);
      logic [CNT_W-1:0] c;
      unique case (p)
         3'd0:    c = CNT_W'(COUNT_POOL0);
         3'd1:    c = CNT_W'(COUNT_POOL1);
         3'd2:    c = CNT_W'(COUNT_POOL2);
         3'd3:    c = CNT_W'(COUNT_POOL3);
         3'd4:    c = CNT_W'(COUNT_POOL4);
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [ROW_W:0] pool_rows(input logic [POOL_W-1:0] p);
      logic [ROW_W:0] r;
      unique case (p)
         3'd0:    r = (ROW_W+1)'(ROWS_P0);
         3'd1:    r = (ROW_W+1)'(ROWS_P1);
         3'd2:    r = (ROW_W+1)'(ROWS_P2);
         3'd3:    r = (ROW_W+1)'(ROWS_P3);
         3'd4:    r = (ROW_W+1)'(ROWS_P4);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [RA_W-1:0] pool_row_base(input logic [POOL_W-1:0] p);
      logic [RA_W-1:0] b;
      unique case (p)
         3'd1:    b = RA_W'(ROW_BASE1);
         3'd2:    b = RA_W'(ROW_BASE2);
         3'd3:    b = RA_W'(ROW_BASE3);
         3'd4:    b = RA_W'(ROW_BASE4);
         default: b = '0;
      endcase
      return b;
   endfunction

   // highest legal offset from the base: (count - 1) * size
   function automatic logic [ADDR_W-1:0] pool_top(input logic [POOL_W-1:0] p);
      logic [ADDR_W-1:0] t;
      unique case (p)
         3'd0:    t = ADDR_W'(longint'(COUNT_POOL0 - 1) * longint'(SIZE0));
         3'd1:    t = ADDR_W'(longint'(COUNT_POOL1 - 1) * longint'(SIZE1));
         3'd2:    t = ADDR_W'(longint'(COUNT_POOL2 - 1) * longint'(SIZE2));
         3'd3:    t = ADDR_W'(longint'(COUNT_POOL3 - 1) * longint'(SIZE3));
         3'd4:    t = ADDR_W'(longint'(COUNT_POOL4 - 1) * longint'(SIZE4));
         default: t = '0;
      endcase
      return t;
   endfunction

   // bits past the pool's last slot in its last row read as taken
   function automatic logic [ROW_BITS-1:0] pad_mask(input logic [POOL_W-1:0] p,
                                                    input logic [ROW_W-1:0] row);
      logic [CNT_W-1:0]    cnt;
      logic [ROW_W:0]      last;
      logic [BIT_W-1:0]    rem;
      logic [ROW_BITS-1:0] m;
      cnt  = pool_count(p);
      last = pool_rows(p) - 1'b1;
      rem  = cnt[BIT_W-1:0];
      m    = '0;
      if ({1'b0, row} == last && rem != '0) begin
         m = ~((ROW_BITS'(1) << rem) - ROW_BITS'(1));
      end
      return m;
   endfunction

endpackage

// ===== hw/rtl/multi_pool_slot_allocator.sv =====
// The result strobe is registered; rejects and full pools are
// fastest, allocate takes longest (bitmap row read, write back, multiply, add).
// The front end takes no new request while an earlier one is in its stages or the queue
// is full; the back end finishes each item before it pops the next one.
// Reset is synchronous: it clears base registers and row flags at once, no clearing pass.
// Top level of the multi-pool slot allocator; depends on mpsa_pkg and all mpsa_ modules.
`timescale 1ns / 1ps

module multi_pool_slot_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mpsa_pkg::ACT_W-1:0]         req_action,
   input  logic [mpsa_pkg::POOL_W-1:0]        req_pool,
   input  logic signed [mpsa_pkg::SIDX_W-1:0] req_slot_index,
   input  logic [mpsa_pkg::ADDR_W-1:0]        req_slot_address,
   output logic                               rsp_strobe,
   output logic [mpsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [mpsa_pkg::RIDX_W-1:0] rsp_result_index,
   output logic [mpsa_pkg::ADDR_W-1:0]        rsp_result_address,
   input  logic                               csr_we,
   input  logic [mpsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mpsa_pkg::ADDR_W-1:0]        csr_wdata
);
   import mpsa_pkg::*;

   logic   q_full;
   logic   q_empty;
   logic   push;
   logic   pop;
   op_type push_op;
   op_type head;

   mpsa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_pool         (req_pool),
      .req_slot_index   (req_slot_index),
      .req_slot_address (req_slot_address),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .push             (push),
      .push_op          (push_op)
   );

   mpsa_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (pop),
      .pop_op  (head),
      .empty   (q_empty)
   );

   mpsa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (q_empty),
      .head               (head),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_result_index   (rsp_result_index),
      .rsp_result_address (rsp_result_address)
   );
endmodule

// ===== hw/rtl/mpsa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mpsa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/mpsa_front.sv =====
// Front end: holds the base registers, accepts requests, checks ranges and
// turns each request into a queue entry. Depends on mpsa_pkg.
`timescale 1ns / 1ps

module mpsa_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mpsa_pkg::ACT_W-1:0]       req_action,
   input  logic [mpsa_pkg::POOL_W-1:0]      req_pool,
   input  logic signed [mpsa_pkg::SIDX_W-1:0] req_slot_index,
   input  logic [mpsa_pkg::ADDR_W-1:0]      req_slot_address,
   input  logic                             csr_we,
   input  logic [mpsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mpsa_pkg::ADDR_W-1:0]      csr_wdata,
   input  logic                             q_full,
   output logic                             push,
   output mpsa_pkg::op_type                 push_op
);
   import mpsa_pkg::*;

   logic [ADDR_W-1:0] base_ff [NUM_POOLS];

   logic              s1_v_ff, s1_v_in;
   action_type        s1_act_ff;
   logic [POOL_W-1:0] s1_pool_ff;
   logic              s1_pool_ok_ff;
   logic [SIDX_W-1:0] s1_sidx_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [ADDR_W-1:0] s1_base_ff;

   logic              s2_v_ff, s2_v_in;
   op_kind_type       s2_kind_ff, s2_kind_in;
   logic [POOL_W-1:0] s2_pool_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [ADDR_W-1:0] s2_off_ff, s2_off_in;
   logic [ADDR_W-1:0] s2_base_ff;
   logic              s2_byaddr_ff;

   logic                     accept;
   logic [CNT_W-1:0]         cnt;
   logic                     idx_ok;
   logic                     off_ok;
   logic [X3_W-1:0]          x3;
   logic [X3_W+DIV3_K-1:0]   q3_prod;
   logic [IDX_W-1:0]         q;

   assign busy   = s1_v_ff | s2_v_ff | q_full;
   assign accept = start & ~busy;

   // write base registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POOLS; i++) begin
            base_ff[i] <= '0;
         end
      end else if (csr_we && csr_index < CSR_IDX_W'(NUM_POOLS)) begin
         base_ff[csr_index] <= csr_wdata;
      end
   end

   // stage one: capture request and its pool base
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff     <= action_type'(req_action);
         s1_pool_ff    <= req_pool;
         s1_pool_ok_ff <= req_pool < POOL_W'(NUM_POOLS);
         s1_sidx_ff    <= req_slot_index;
         s1_addr_ff    <= req_slot_address;
         s1_base_ff    <= (req_pool < POOL_W'(NUM_POOLS)) ? base_ff[req_pool] : '0;
      end
   end

   // classify: range checks on index and address offset
   always_comb begin
      cnt       = pool_count(s1_pool_ff);
      idx_ok    = ~s1_sidx_ff[SIDX_W-1] && ({1'b0, s1_sidx_ff[SIDX_W-2:0]} < cnt);
      s2_off_in = s1_addr_ff - s1_base_ff;
      off_ok    = s2_off_in <= pool_top(s1_pool_ff);
      s2_kind_in = OP_REJECT;
      if (s1_pool_ok_ff) begin
         unique case (s1_act_ff)
            ACT_ALLOC:     s2_kind_in = OP_ALLOC;
            ACT_FREE_IDX:  s2_kind_in = idx_ok ? OP_FREE : OP_REJECT;
            ACT_FREE_ADDR: s2_kind_in = off_ok ? OP_FREE : OP_REJECT;
            ACT_GET:       s2_kind_in = idx_ok ? OP_GET : OP_REJECT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         s2_kind_ff   <= s2_kind_in;
         s2_pool_ff   <= s1_pool_ff;
         s2_idx_ff    <= s1_sidx_ff[IDX_W-1:0];
         s2_off_ff    <= s2_off_in;
         s2_base_ff   <= s1_base_ff;
         s2_byaddr_ff <= s1_act_ff == ACT_FREE_ADDR;
      end
   end

   // stage two: offset to slot index
   always_comb begin
      x3      = X3_W'(s2_off_ff >> SIZE0_SH);
      q3_prod = (X3_W+DIV3_K)'(x3) * (X3_W+DIV3_K)'(DIV3_M);
      unique case (s2_pool_ff)
         3'd0:    q = IDX_W'(q3_prod >> DIV3_K);
         3'd1:    q = IDX_W'(s2_off_ff >> SIZE1_SH);
         3'd2:    q = IDX_W'(s2_off_ff >> SIZE2_SH);
         3'd3:    q = IDX_W'(s2_off_ff >> SIZE3_SH);
         3'd4:    q = IDX_W'(s2_off_ff >> SIZE4_SH);
         default: q = '0;
      endcase
      push_op.kind = s2_kind_ff;
      push_op.pool = s2_pool_ff;
      push_op.idx  = s2_byaddr_ff ? q : s2_idx_ff;
      push_op.base = s2_base_ff;
      push         = s2_v_ff & ~q_full;
   end

   // advance valid flags
   always_comb begin
      s1_v_in = accept;
      s2_v_in = s1_v_ff | (s2_v_ff & ~push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end
endmodule

// ===== hw/rtl/mpsa_fifo.sv =====
// Short queue of classified items between front end and back end.
// Depends on mpsa_pkg.
`timescale 1ns / 1ps

module mpsa_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mpsa_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output mpsa_pkg::op_type pop_op,
   output logic             empty
);
   import mpsa_pkg::*;

   op_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;

   assign full   = cnt_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign empty  = cnt_ff == '0;
   assign pop_op = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
`endif
endmodule

// ===== hw/rtl/mpsa_back.sv =====
// Back end: bitmap read-modify-write, lowest-free search and address compute.
// Depends on mpsa_pkg and mpsa_ram.
`timescale 1ns / 1ps

module mpsa_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               empty,
   input  mpsa_pkg::op_type                   head,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic [mpsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [mpsa_pkg::RIDX_W-1:0] rsp_result_index,
   output logic [mpsa_pkg::ADDR_W-1:0]        rsp_result_address
);
   import mpsa_pkg::*;

   bk_state_type      st_ff, st_in;
   op_type            op_ff, op_in;
   logic [RA_W-1:0]   row_addr_ff, row_addr_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              full_ff [ROWS_TOTAL];
   logic              rv_ff [ROWS_TOTAL];

   logic              rsp_strobe_ff;
   status_type        rsp_status_ff;
   logic [RIDX_W-1:0] rsp_index_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;

   logic                emit;
   status_type          emit_status;
   logic [RIDX_W-1:0]   emit_index;
   logic [ADDR_W-1:0]   emit_addr;

   logic [ROWS_MAX-1:0] nf;
   logic                row_found;
   logic [ROW_W-1:0]    frow;
   logic [ROW_BITS-1:0] rdata;
   logic [ROW_BITS-1:0] eff;
   logic                zfound;
   logic [BIT_W-1:0]    zb;
   logic                tbl_we;
   logic [ROW_BITS-1:0] wdata;
   logic                full_new;

   mpsa_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS_TOTAL)
   ) u_bitmap (
      .clock (clock),
      .we    (tbl_we),
      .waddr (row_addr_ff),
      .wdata (wdata),
      .raddr (row_addr_in),
      .rdata (rdata)
   );

   // find lowest row of the head's pool with a free slot
   always_comb begin
      logic [RA_W:0] fidx;
      nf        = '0;
      row_found = 1'b0;
      frow      = '0;
      for (int r = 0; r < ROWS_MAX; r++) begin
         fidx = (RA_W+1)'(pool_row_base(head.pool)) + (RA_W+1)'(r);
         if ((ROW_W+1)'(r) < pool_rows(head.pool)) begin
            nf[r] = ~full_ff[fidx[RA_W-1:0]];
         end
      end
      for (int r = ROWS_MAX - 1; r >= 0; r--) begin
         if (nf[r]) begin
            row_found = 1'b1;
            frow      = ROW_W'(r);
         end
      end
   end

   // lowest clear bit of the current row; rows never written read as free
   always_comb begin
      eff    = rv_ff[row_addr_ff] ? rdata : '0;
      zfound = 1'b0;
      zb     = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (!eff[b]) begin
            zfound = 1'b1;
            zb     = BIT_W'(b);
         end
      end
   end

   // sequencer: next state, table updates and result
   always_comb begin
      st_in       = st_ff;
      op_in       = op_ff;
      row_addr_in = row_addr_ff;
      prod_in     = prod_ff;
      pop         = 1'b0;
      tbl_we      = 1'b0;
      wdata       = eff;
      full_new    = 1'b0;
      emit        = 1'b0;
      emit_status = ST_INVALID;
      emit_index  = '1;
      emit_addr   = '0;
      unique case (st_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop   = 1'b1;
               op_in = head;
               unique case (head.kind)
                  OP_ALLOC: begin
                     if (row_found) begin
                        op_in.idx   = {frow, BIT_W'(0)};
                        row_addr_in = pool_row_base(head.pool) + RA_W'(frow);
                        st_in       = BK_CHK;
                     end else begin
                        emit        = 1'b1;
                        emit_status = ST_NO_SLOT;
                     end
                  end
                  OP_FREE: begin
                     row_addr_in = pool_row_base(head.pool) + RA_W'(head.idx[IDX_W-1:BIT_W]);
                     st_in       = BK_CHK;
                  end
                  OP_GET: begin
                     st_in = BK_MUL;
                  end
                  OP_REJECT: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         BK_CHK: begin
            if (op_ff.kind == OP_ALLOC) begin
               wdata     = eff | (ROW_BITS'(1) << zb);
               tbl_we    = 1'b1;
               full_new  = &(wdata | pad_mask(op_ff.pool, op_ff.idx[IDX_W-1:BIT_W]));
               op_in.idx = {op_ff.idx[IDX_W-1:BIT_W], zb};
               st_in     = BK_MUL;
            end else begin
               if (eff[op_ff.idx[BIT_W-1:0]]) begin
                  wdata       = eff & ~(ROW_BITS'(1) << op_ff.idx[BIT_W-1:0]);
                  tbl_we      = 1'b1;
                  emit_status = ST_OK;
               end
               emit  = 1'b1;
               st_in = BK_IDLE;
            end
         end
         BK_MUL: begin
            unique case (op_ff.pool)
               3'd0: prod_in = ((PROD_W'(op_ff.idx) << 1) + PROD_W'(op_ff.idx)) << SIZE0_SH;
               3'd1: prod_in = PROD_W'(op_ff.idx) << SIZE1_SH;
               3'd2: prod_in = PROD_W'(op_ff.idx) << SIZE2_SH;
               3'd3: prod_in = PROD_W'(op_ff.idx) << SIZE3_SH;
               default: prod_in = PROD_W'(op_ff.idx) << SIZE4_SH;
            endcase
            st_in = BK_ADD;
         end
         BK_ADD: begin
            emit        = 1'b1;
            emit_status = ST_OK;
            emit_index  = (op_ff.kind == OP_ALLOC) ? RIDX_W'(op_ff.idx) : '1;
            emit_addr   = op_ff.base + ADDR_W'(prod_ff);
            st_in       = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_addr_ff <= row_addr_in;
      prod_ff     <= prod_in;
   end

   // row flags: written and full, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS_TOTAL; i++) begin
            full_ff[i] <= 1'b0;
            rv_ff[i]   <= 1'b0;
         end
      end else if (tbl_we) begin
         full_ff[row_addr_ff] <= full_new;
         rv_ff[row_addr_ff]   <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_index_ff  <= emit_index;
         rsp_addr_ff   <= emit_addr;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_index   = rsp_index_ff;
   assign rsp_result_address = rsp_addr_ff;

`ifndef SYNTHESIS
   a_alloc_row_has_room: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_CHK && op_ff.kind == OP_ALLOC) |-> zfound)
      else $error("allocate picked a row with no free slot");
   a_mul_only_addr_ops: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_MUL) |-> (op_ff.kind == OP_ALLOC || op_ff.kind == OP_GET))
      else $error("address compute for an item without an address");
`endif
endmodule
